FILE: design/cal_pkg.sv
// Shared types and constants for the cursor array list.
`timescale 1ns / 1ps

package cal_pkg;

    localparam int CAL_CAPACITY = 32;
    localparam int REQ_W        = 3;
    localparam int STAT_W       = 3;
    localparam int VALUE_W      = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_NEXT      = 3'd0,
        REQ_BACK      = 3'd1,
        REQ_INSERT    = 3'd2,
        REQ_OVERWRITE = 3'd3,
        REQ_REMOVE    = 3'd4,
        REQ_TO_END    = 3'd5,
        REQ_TO_START  = 3'd6
    } cal_req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_AT_END   = 3'd1,
        ST_AT_START = 3'd2,
        ST_FULL     = 3'd3,
        ST_NO_ENTRY = 3'd4
    } cal_status_t;

    typedef enum logic {
        CAL_IDLE = 1'b0,
        CAL_EXEC = 1'b1
    } cal_state_t;

    typedef struct packed {
        logic load;
        logic commit;
    } cal_cmd_t;

endpackage

FILE: design/cal_ctrl.sv
// Controller for the cursor array list: request capture and response handoff.
`timescale 1ns / 1ps

module cal_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cal_pkg::cal_cmd_t cmd
);
    import cal_pkg::*;

    cal_state_t state_reg;
    cal_state_t state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       rsp_free;

    // response slot is free if empty or being drained this cycle
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CAL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CAL_EXEC;
                end
            end
            CAL_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = CAL_IDLE;
                end
            end
            default:
            begin
                state_next = CAL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load       = 1'b0;
        cmd.commit     = 1'b0;
        req_stall      = 1'b1;
        case (state_reg)
            CAL_IDLE:
            begin
                req_stall = 1'b0;
                cmd.load  = req_valid;
            end
            CAL_EXEC:
            begin
                cmd.commit = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
        rsp_valid_next = cmd.commit || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CAL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: design/cal_datapath.sv
// Datapath for the cursor array list: entry row, cursor, count and status.
`timescale 1ns / 1ps

module cal_datapath #(
    parameter  int CAPACITY = cal_pkg::CAL_CAPACITY,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CUR_W    = IDX_W + 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cal_pkg::cal_cmd_t                 cmd,
    input  logic [cal_pkg::REQ_W-1:0]         req_type,
    input  logic signed [cal_pkg::VALUE_W-1:0] value,
    output logic [cal_pkg::STAT_W-1:0]        status,
    output logic signed [CUR_W-1:0]           cursor_pos,
    output logic [CNT_W-1:0]                  entry_count,
    output logic signed [cal_pkg::VALUE_W-1:0] cursor_value
);
    import cal_pkg::*;

    logic [REQ_W-1:0]   req_reg;
    logic [VALUE_W-1:0] value_reg;

    cal_status_t        status_reg;
    cal_status_t        status_next;
    logic [CUR_W-1:0]   cursor_reg;
    logic [CUR_W-1:0]   cursor_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    logic [VALUE_W-1:0] store_reg  [CAPACITY];
    logic [VALUE_W-1:0] store_next [CAPACITY];

    logic               cur_neg;
    logic [CUR_W-1:0]   cur_plus1;
    logic [CUR_W-1:0]   cur_minus1;
    logic [CUR_W-1:0]   count_ext;
    logic               is_full;
    logic [IDX_W-1:0]   ins_pos;
    logic [IDX_W-1:0]   cur_idx;
    logic               ins_en;
    logic               ovw_en;
    logic               rem_en;

    assign cur_neg    = cursor_reg[CUR_W-1];
    assign cur_plus1  = cursor_reg + CUR_W'(1);
    assign cur_minus1 = cursor_reg - CUR_W'(1);
    assign count_ext  = CUR_W'(count_reg);
    assign is_full    = (count_reg == CNT_W'(CAPACITY));
    assign ins_pos    = cur_plus1[IDX_W-1:0];
    assign cur_idx    = cursor_reg[IDX_W-1:0];

    assign ins_en = (cal_req_t'(req_reg) == REQ_INSERT) && !is_full;
    assign ovw_en = (cal_req_t'(req_reg) == REQ_OVERWRITE) && !cur_neg;
    assign rem_en = (cal_req_t'(req_reg) == REQ_REMOVE) && !cur_neg;

    always_comb
    begin
        status_next = ST_OK;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        case (cal_req_t'(req_reg))
            REQ_NEXT:
            begin
                if (cur_plus1 >= count_ext)
                    status_next = ST_AT_END;
                else
                    cursor_next = cur_plus1;
            end
            REQ_BACK:
            begin
                if (cur_neg)
                    status_next = ST_AT_START;
                else
                    cursor_next = cur_minus1;
            end
            REQ_INSERT:
            begin
                if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    cursor_next = cur_plus1;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            REQ_OVERWRITE:
            begin
                if (cur_neg)
                    status_next = ST_NO_ENTRY;
            end
            REQ_REMOVE:
            begin
                if (cur_neg)
                    status_next = ST_NO_ENTRY;
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    // removing the last entry pulls the cursor back one
                    if (cur_plus1 == count_ext)
                        cursor_next = cur_minus1;
                end
            end
            REQ_TO_END:
            begin
                cursor_next = count_ext - CUR_W'(1);
            end
            REQ_TO_START:
            begin
                cursor_next = '1;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // each entry picks its own value, the new value, its lower or its upper neighbor
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_entry
        logic [VALUE_W-1:0] from_below;
        logic [VALUE_W-1:0] from_above;

        if (g == 0)
        begin : g_first
            assign from_below = store_reg[g];
        end
        else
        begin : g_mid
            assign from_below = store_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign from_above = store_reg[g];
        end
        else
        begin : g_upper
            assign from_above = store_reg[g+1];
        end

        always_comb
        begin
            store_next[g] = store_reg[g];
            if (ins_en)
            begin
                if (ins_pos == IDX_W'(g))
                    store_next[g] = value_reg;
                else if (ins_pos < IDX_W'(g))
                    store_next[g] = from_below;
            end
            else if (ovw_en)
            begin
                if (cur_idx == IDX_W'(g))
                    store_next[g] = value_reg;
            end
            else if (rem_en)
            begin
                if (cur_idx <= IDX_W'(g))
                    store_next[g] = from_above;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            value_reg <= value;
        end
        if (cmd.commit)
        begin
            store_reg <= store_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= ST_OK;
            cursor_reg <= '1;
            count_reg  <= '0;
        end
        else if (cmd.commit)
        begin
            status_reg <= status_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    // state only changes on commit, so these hold while the word is stalled
    assign status       = status_reg;
    assign cursor_pos   = cursor_reg;
    assign entry_count  = count_reg;
    assign cursor_value = cur_neg ? '0 : store_reg[cur_idx];

endmodule

FILE: design/cursor_array_list.sv
// Top level of the cursor array list.
// The controller captures a request in IDLE, then in EXEC commits it to the entry row
// and sets the registered response valid once the response register is free.
// A new request is stalled until the current one has been committed.
// Reset: cursor at -1 and count zero; entry contents are undefined until written.
`timescale 1ns / 1ps

module cursor_array_list #(
    parameter  int CAPACITY = cal_pkg::CAL_CAPACITY,
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CUR_W    = IDX_W + 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [cal_pkg::REQ_W-1:0]          req_type,
    input  logic signed [cal_pkg::VALUE_W-1:0] value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [cal_pkg::STAT_W-1:0]         status,
    output logic signed [CUR_W-1:0]            cursor_pos,
    output logic [CNT_W-1:0]                   entry_count,
    output logic signed [cal_pkg::VALUE_W-1:0] cursor_value
);
    import cal_pkg::*;

    cal_cmd_t cmd;

    cal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    cal_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .req_type     (req_type),
        .value        (value),
        .status       (status),
        .cursor_pos   (cursor_pos),
        .entry_count  (entry_count),
        .cursor_value (cursor_value)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the cursor array list: directed edge cases, then random traffic.
`timescale 1ns / 1ps

module testbench;

    import cal_pkg::*;

    localparam int CUR_W       = $clog2(CAL_CAPACITY) + 1;
    localparam int CNT_W       = $clog2(CAL_CAPACITY + 1);
    localparam int HOLD_LEN    = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAUSE = 8;

    // request code the block must treat as a no-op
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int {
        MOOD_GROW,
        MOOD_SHRINK,
        MOOD_MIXED
    } list_mood_t;

    typedef struct packed {
        cal_status_t                st;
        logic signed [CUR_W-1:0]    cur;
        logic [CNT_W-1:0]           cnt;
        logic signed [VALUE_W-1:0]  val;
    } list_rsp_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       req_valid = 1'b0;
    logic                       req_stall;
    logic [REQ_W-1:0]           req_type = '0;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic [STAT_W-1:0]          status;
    logic signed [CUR_W-1:0]    cursor_pos;
    logic [CNT_W-1:0]           entry_count;
    logic signed [VALUE_W-1:0]  cursor_value;

    // shadow copy of the list
    logic signed [VALUE_W-1:0]  list_mem [CAL_CAPACITY];
    int                         list_cursor = -1;
    int                         list_count = 0;

    list_rsp_t                  pending_rsp [$];
    list_rsp_t                  exp_rsp;
    int                         mismatches = 0;
    int                         quiet_cycles = 0;
    int                         send_idle_pct = 0;
    int                         rsp_idle_pct = 0;
    int                         hold_seq = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;

    cursor_array_list uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .req_type     (req_type),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .cursor_pos   (cursor_pos),
        .entry_count  (entry_count),
        .cursor_value (cursor_value)
    );

    always #10 clk = ~clk;

    function automatic list_rsp_t predict_list(input logic [REQ_W-1:0] rt,
                                               input logic signed [VALUE_W-1:0] v);
        list_rsp_t r;
        int i;
        r.st = ST_OK;
        case (rt)
            REQ_NEXT:
                if (list_cursor + 1 >= list_count)
                    r.st = ST_AT_END;
                else
                    list_cursor++;
            REQ_BACK:
                if (list_cursor < 0)
                    r.st = ST_AT_START;
                else
                    list_cursor--;
            REQ_INSERT:
                if (list_count >= CAL_CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    for (i = list_count; i > list_cursor + 1; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[list_cursor + 1] = v;
                    list_cursor++;
                    list_count++;
                end
            REQ_OVERWRITE:
                if (list_cursor < 0)
                    r.st = ST_NO_ENTRY;
                else
                    list_mem[list_cursor] = v;
            REQ_REMOVE:
                if (list_cursor < 0)
                    r.st = ST_NO_ENTRY;
                else
                begin
                    for (i = list_cursor; i + 1 < list_count; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_count--;
                    if (list_cursor >= list_count)
                        list_cursor = list_count - 1;
                end
            REQ_TO_END:
                list_cursor = list_count - 1;
            REQ_TO_START:
                list_cursor = -1;
            default:
                ;
        endcase
        r.cur = CUR_W'(list_cursor);
        r.cnt = CNT_W'(list_count);
        r.val = (list_cursor >= 0) ? list_mem[list_cursor] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // Push the prediction before popping, so same-edge request and response stay ordered.
    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            pending_rsp.push_back(predict_list(req_type, value));
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch("unexpected response word", 0, 1);
            else
            begin
                exp_rsp = pending_rsp.pop_front();
                if (status !== exp_rsp.st)
                    report_mismatch("status", exp_rsp.st, status);
                if (cursor_pos !== exp_rsp.cur)
                    report_mismatch("cursor_pos", exp_rsp.cur, cursor_pos);
                if (entry_count !== exp_rsp.cnt)
                    report_mismatch("entry_count", exp_rsp.cnt, entry_count);
                if (cursor_value !== exp_rsp.val)
                    report_mismatch("cursor_value", exp_rsp.val, cursor_value);
            end
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // response back-pressure; a new hold_seq starts a long hold-off
    always @(posedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_LEN;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
    end

    task automatic send_word(input logic [REQ_W-1:0] rt, input logic signed [VALUE_W-1:0] v);
        // each cycle before offering, the sender idles with the set odds
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type  <= rt;
        value     <= v;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input list_mood_t mood);
        int ins;
        int rem;
        int r;
        ins = (mood == MOOD_GROW) ? 45 : (mood == MOOD_SHRINK) ? 10 : 22;
        rem = (mood == MOOD_GROW) ? 8 : (mood == MOOD_SHRINK) ? 40 : 20;
        r = $urandom_range(99);
        if (r < ins)
            return REQ_INSERT;
        if (r < ins + rem)
            return REQ_REMOVE;
        r = $urandom_range(99);
        if (r < 25)
            return REQ_NEXT;
        if (r < 50)
            return REQ_BACK;
        if (r < 70)
            return REQ_OVERWRITE;
        if (r < 82)
            return REQ_TO_END;
        if (r < 95)
            return REQ_TO_START;
        return REQ_UNUSED;
    endfunction

    task automatic test_empty_list();
        send_word(REQ_NEXT, 32'sd5);
        send_word(REQ_BACK, 32'sd6);
        send_word(REQ_OVERWRITE, 32'sd7);
        send_word(REQ_REMOVE, -32'sd8);
        send_word(REQ_TO_END, VAL_MAX);
        send_word(REQ_TO_START, VAL_MIN);
        send_word(REQ_UNUSED, -1);
    endtask

    task automatic test_edit_and_move();
        send_word(REQ_INSERT, VAL_MAX);
        send_word(REQ_INSERT, VAL_MIN);
        send_word(REQ_TO_START, '0);
        send_word(REQ_INSERT, '0);          // insert at the head
        send_word(REQ_TO_END, '0);
        send_word(REQ_NEXT, '0);            // already at end
        send_word(REQ_BACK, '0);
        send_word(REQ_OVERWRITE, -1);
        send_word(REQ_BACK, '0);
        send_word(REQ_BACK, '0);
        send_word(REQ_BACK, '0);            // already at start
        send_word(REQ_UNUSED, VAL_MAX);
        send_word(REQ_NEXT, '0);
        send_word(REQ_REMOVE, '0);          // removes from the head
        send_word(REQ_TO_END, '0);
        send_word(REQ_REMOVE, '0);          // cursor clamps back
        send_word(REQ_REMOVE, '0);          // list empties, cursor to -1
    endtask

    // fill past capacity while the response side is held off
    task automatic test_fill_under_holdoff();
        int i;
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
        hold_seq <= hold_seq + 1;
        for (i = 0; i < CAL_CAPACITY + 8; i++)
            send_word(REQ_INSERT, pick_value());
        send_word(REQ_NEXT, '0);
        send_word(REQ_TO_START, '0);
        send_word(REQ_INSERT, '0);
    endtask

    task automatic test_random_traffic(input int n_words, input int send_pct, input int rsp_pct);
        list_mood_t mood;
        int i;
        send_idle_pct = send_pct;
        rsp_idle_pct  = rsp_pct;
        mood = MOOD_MIXED;
        for (i = 0; i < n_words; i++)
        begin
            if (i % 50 == 0)
                mood = list_mood_t'($urandom_range(2));
            send_word(pick_request(mood), pick_value());
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edit_and_move();
        test_fill_under_holdoff();
        test_random_traffic(600, 32, 64);
        test_random_traffic(600, 64, 32);
        test_random_traffic(580, 0, 0);

        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
